[hw/rtl/awtc_pkg.sv]
package awtc_pkg;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int ACC_W   = 64;
  localparam int TW_W    = 48;
  localparam int OUT_W   = 16;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_ABS,
    ST_XLO,
    ST_XHI,
    ST_YLO,
    ST_YHI,
    ST_YFIN,
    ST_YSUM,
    ST_DSTART,
    ST_DRUN
  } state_t;

  // Operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MUL_CA,
    MUL_CB,
    MUL_CC,
    MUL_XL,
    MUL_XH,
    MUL_YL,
    MUL_YH
  } mul_sel_t;

  // Commands to the accumulation datapath
  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     cr_load;
    logic     cr_add;
    logic     w_load;
    logic     tw_add;
    logic     pw_load;
    logic     pw_acc;
    logic     sumx_add;
    logic     sumy_add;
    logic     clear;
  } dp_cmd_t;

  // Commands to the divider and output stage
  typedef struct packed {
    logic start;
    logic out_load;
  } div_cmd_t;

endpackage

[hw/rtl/area_weighted_triangle_centroid.sv]
// The result is registered once the divider has finished and the output register is free.
// A new triangle is accepted only after the previous one has been through the single
// shared multiplier (three cross terms and four half products per triangle).
// After the final triangle the input stalls while the radix-2 divider runs
// (18 steps per axis, x then y); the next triangle may enter while a result waits.
// Reset (synchronous, active low) clears the sums, the flags and the output valid.
module area_weighted_triangle_centroid #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [awtc_pkg::COORD_W-1:0] in_ax,
  input  logic signed [awtc_pkg::COORD_W-1:0] in_ay,
  input  logic signed [awtc_pkg::COORD_W-1:0] in_bx,
  input  logic signed [awtc_pkg::COORD_W-1:0] in_by_coord,
  input  logic signed [awtc_pkg::COORD_W-1:0] in_cx,
  input  logic signed [awtc_pkg::COORD_W-1:0] in_cy,
  input  logic                                in_last_triangle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [awtc_pkg::OUT_W-1:0]   out_centroid_x,
  output logic signed [awtc_pkg::OUT_W-1:0]   out_centroid_y,
  output logic                                out_zero_area,
  output logic                                out_saturated
);
  import awtc_pkg::*;

  dp_cmd_t                 dp_cmd;
  div_cmd_t                div_cmd;
  logic                    last;
  logic                    div_busy;
  logic signed [ACC_W-1:0] sum_x, sum_y;
  logic        [TW_W-1:0]  tw;
  logic                    ovf;

  // Sequence the requests
  awtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .div_busy  (div_busy),
    .dp_cmd    (dp_cmd),
    .div_cmd   (div_cmd)
  );

  // Weight and accumulate each triangle
  awtc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .ax            (in_ax),
    .ay            (in_ay),
    .bx            (in_bx),
    .by_coord      (in_by_coord),
    .cx            (in_cx),
    .cy            (in_cy),
    .last_triangle (in_last_triangle),
    .last          (last),
    .sum_x         (sum_x),
    .sum_y         (sum_y),
    .tw            (tw),
    .ovf           (ovf)
  );

  // Divide by three times the total weight and hold the result
  awtc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (div_cmd),
    .sum_x      (sum_x),
    .sum_y      (sum_y),
    .tw         (tw),
    .ovf        (ovf),
    .busy       (div_busy),
    .centroid_x (out_centroid_x),
    .centroid_y (out_centroid_y),
    .zero_area  (out_zero_area),
    .saturated  (out_saturated)
  );

endmodule

[hw/rtl/awtc_ctrl.sv]
module awtc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              last,
  input  logic              div_busy,
  output awtc_pkg::dp_cmd_t dp_cmd,
  output awtc_pkg::div_cmd_t div_cmd
);
  import awtc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one triangle through the shared multiplier, then divide at shape end
  always_comb begin
    state_nxt       = state_r;
    dp_cmd          = '0;
    dp_cmd.mul_sel  = MUL_CA;
    div_cmd         = '0;
    in_stall        = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = ST_C0;
        end
      end
      ST_C0: begin
        dp_cmd.mul_sel = MUL_CA;
        state_nxt      = ST_C1;
      end
      ST_C1: begin
        dp_cmd.mul_sel = MUL_CB;
        dp_cmd.cr_load = 1'b1;
        state_nxt      = ST_C2;
      end
      ST_C2: begin
        dp_cmd.mul_sel = MUL_CC;
        dp_cmd.cr_add  = 1'b1;
        state_nxt      = ST_ABS;
      end
      ST_ABS: begin
        dp_cmd.w_load = 1'b1;
        state_nxt     = ST_XLO;
      end
      ST_XLO: begin
        dp_cmd.mul_sel = MUL_XL;
        dp_cmd.tw_add  = 1'b1;
        state_nxt      = ST_XHI;
      end
      ST_XHI: begin
        dp_cmd.mul_sel = MUL_XH;
        dp_cmd.pw_load = 1'b1;
        state_nxt      = ST_YLO;
      end
      ST_YLO: begin
        dp_cmd.mul_sel = MUL_YL;
        dp_cmd.pw_acc  = 1'b1;
        state_nxt      = ST_YHI;
      end
      ST_YHI: begin
        dp_cmd.mul_sel  = MUL_YH;
        dp_cmd.sumx_add = 1'b1;
        dp_cmd.pw_load  = 1'b1;
        state_nxt       = ST_YFIN;
      end
      ST_YFIN: begin
        dp_cmd.pw_acc = 1'b1;
        state_nxt     = ST_YSUM;
      end
      ST_YSUM: begin
        dp_cmd.sumy_add = 1'b1;
        if (last) begin
          state_nxt = ST_DSTART;
        end else begin
          in_stall = 1'b0;
          if (in_valid) begin
            dp_cmd.load = 1'b1;
            state_nxt   = ST_C0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DSTART: begin
        dp_cmd.clear  = 1'b1;
        div_cmd.start = 1'b1;
        state_nxt     = ST_DRUN;
      end
      ST_DRUN: begin
        if (!div_busy && (!out_valid_r || !out_stall)) begin
          div_cmd.out_load = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result until taken
  assign out_valid_nxt = div_cmd.out_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

`ifndef SYNTHESIS
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRUN || state_r == ST_DSTART) |-> in_stall)
    else $error("request accepted during divide");
  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while waiting");
  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.clear |-> (last && $past(state_r) == ST_YSUM))
    else $error("sums cleared before shape end");
`endif

endmodule

[hw/rtl/awtc_dp.sv]
module awtc_dp #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  awtc_pkg::dp_cmd_t                   cmd,
  input  logic signed [awtc_pkg::COORD_W-1:0] ax,
  input  logic signed [awtc_pkg::COORD_W-1:0] ay,
  input  logic signed [awtc_pkg::COORD_W-1:0] bx,
  input  logic signed [awtc_pkg::COORD_W-1:0] by_coord,
  input  logic signed [awtc_pkg::COORD_W-1:0] cx,
  input  logic signed [awtc_pkg::COORD_W-1:0] cy,
  input  logic                                last_triangle,
  output logic                                last,
  output logic signed [awtc_pkg::ACC_W-1:0]   sum_x,
  output logic signed [awtc_pkg::ACC_W-1:0]   sum_y,
  output logic        [awtc_pkg::TW_W-1:0]    tw,
  output logic                                ovf
);
  import awtc_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = (CW > COORD_W) ? CW : COORD_W;
  localparam int MW = CW + 2;        // multiplier operand width
  localparam int PM = 2 * MW;        // product width
  localparam int WW = 2 * CW + 1;    // weight width
  localparam int HL = CW + 1;        // low half of the weight
  localparam int PW = 3 * CW + 3;    // full weighted product width
  localparam logic [ACC_W-1:0] SAT_POS = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_NEG = {1'b1, {(ACC_W-1){1'b0}}};

  // Keep the low COORD_BITS bits as a signed coordinate
  function automatic logic signed [CW-1:0] to_coord(input logic [COORD_W-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[CW-1:0];
  endfunction

  // Signed add into the 64-bit sum, clamped; top bit flags saturation
  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                              input logic signed [PW-1:0] b);
    logic [ACC_W:0] t;
    t = {a[ACC_W-1], a} + {{(ACC_W+1-PW){b[PW-1]}}, b};
    if (t[ACC_W] != t[ACC_W-1]) begin
      return {1'b1, (t[ACC_W] ? SAT_NEG : SAT_POS)};
    end
    return {1'b0, t[ACC_W-1:0]};
  endfunction

  logic signed [CW-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic signed [CW-1:0] ax_r, bx_r, cx_r;
  logic signed [CW:0]   dbc_r, dca_r, dab_r;
  logic signed [MW-1:0] sx_r, sy_r;
  logic                 last_r;
  logic signed [MW-1:0] ma, mb;
  logic signed [PM-1:0] prod, p_r, cr_r, cr_sum, cr_abs;
  logic        [WW-1:0] w_r;
  logic signed [PW-1:0] pext, pw_r;
  logic signed [ACC_W-1:0] sum_x_r, sum_y_r;
  logic        [TW_W-1:0]  tw_r;
  logic                    ovf_r;
  logic        [ACC_W:0]   sx_add, sy_add;
  logic        [TW_W:0]    tw_add;

  assign a_x = to_coord(ax);
  assign a_y = to_coord(ay);
  assign b_x = to_coord(bx);
  assign b_y = to_coord(by_coord);
  assign c_x = to_coord(cx);
  assign c_y = to_coord(cy);

  // Capture the request with its edge differences and vertex sums
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= a_x;
      bx_r   <= b_x;
      cx_r   <= c_x;
      dbc_r  <= {b_y[CW-1], b_y} - {c_y[CW-1], c_y};
      dca_r  <= {c_y[CW-1], c_y} - {a_y[CW-1], a_y};
      dab_r  <= {a_y[CW-1], a_y} - {b_y[CW-1], b_y};
      sx_r   <= {{2{a_x[CW-1]}}, a_x} + {{2{b_x[CW-1]}}, b_x} + {{2{c_x[CW-1]}}, c_x};
      sy_r   <= {{2{a_y[CW-1]}}, a_y} + {{2{b_y[CW-1]}}, b_y} + {{2{c_y[CW-1]}}, c_y};
      last_r <= last_triangle;
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_CA: begin
        ma = {{2{ax_r[CW-1]}}, ax_r};
        mb = {dbc_r[CW], dbc_r};
      end
      MUL_CB: begin
        ma = {{2{bx_r[CW-1]}}, bx_r};
        mb = {dca_r[CW], dca_r};
      end
      MUL_CC: begin
        ma = {{2{cx_r[CW-1]}}, cx_r};
        mb = {dab_r[CW], dab_r};
      end
      MUL_XL: begin
        ma = sx_r;
        mb = {1'b0, w_r[HL-1:0]};
      end
      MUL_XH: begin
        ma = sx_r;
        mb = {2'b00, w_r[WW-1:HL]};
      end
      MUL_YL: begin
        ma = sy_r;
        mb = {1'b0, w_r[HL-1:0]};
      end
      MUL_YH: begin
        ma = sy_r;
        mb = {2'b00, w_r[WW-1:HL]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign cr_sum = cr_r + p_r;
  assign cr_abs = cr_sum[PM-1] ? -cr_sum : cr_sum;
  assign pext   = {{(PW-PM){p_r[PM-1]}}, p_r};
  assign sx_add = sat_add(sum_x_r, pw_r);
  assign sy_add = sat_add(sum_y_r, pw_r);
  assign tw_add = {1'b0, tw_r} + {{(TW_W+1-WW){1'b0}}, w_r};

  // Product, cross product, weight and split-product registers
  always_ff @(posedge clk) begin
    p_r <= prod;
    if (cmd.cr_load) begin
      cr_r <= p_r;
    end else if (cmd.cr_add) begin
      cr_r <= cr_sum;
    end
    if (cmd.w_load) begin
      w_r <= cr_abs[WW-1:0];
    end
    if (cmd.pw_load) begin
      pw_r <= pext;
    end else if (cmd.pw_acc) begin
      pw_r <= pw_r + (pext <<< HL);
    end
  end

  // Running sums: clamp on overflow and remember it
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      tw_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.sumx_add) begin
        sum_x_r <= sx_add[ACC_W-1:0];
      end
      if (cmd.sumy_add) begin
        sum_y_r <= sy_add[ACC_W-1:0];
      end
      if (cmd.tw_add) begin
        tw_r <= tw_add[TW_W] ? {TW_W{1'b1}} : tw_add[TW_W-1:0];
      end
      ovf_r <= ovf_r | (cmd.sumx_add & sx_add[ACC_W]) | (cmd.sumy_add & sy_add[ACC_W])
               | (cmd.tw_add & tw_add[TW_W]);
    end
  end

  assign last  = last_r;
  assign sum_x = sum_x_r;
  assign sum_y = sum_y_r;
  assign tw    = tw_r;
  assign ovf   = ovf_r;

endmodule

[hw/rtl/awtc_div.sv]
module awtc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  awtc_pkg::div_cmd_t                cmd,
  input  logic signed [awtc_pkg::ACC_W-1:0] sum_x,
  input  logic signed [awtc_pkg::ACC_W-1:0] sum_y,
  input  logic        [awtc_pkg::TW_W-1:0]  tw,
  input  logic                              ovf,
  output logic                              busy,
  output logic signed [awtc_pkg::OUT_W-1:0] centroid_x,
  output logic signed [awtc_pkg::OUT_W-1:0] centroid_y,
  output logic                              zero_area,
  output logic                              saturated
);
  import awtc_pkg::*;

  localparam int QB    = 18;              // quotient bits, top bit catches overflow
  localparam int DW    = TW_W + 2;        // three times the total weight
  localparam int DSW   = DW + QB - 1;     // divisor aligned to the top quotient bit
  localparam int CNT_W = $clog2(QB);
  localparam logic [QB-1:0]    Q_POS_LIM = QB'(32767);
  localparam logic [QB-1:0]    Q_NEG_LIM = QB'(32768);
  localparam logic [OUT_W-1:0] OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic logic [ACC_W-1:0] magnitude(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] n;
    n = -v;
    return v[ACC_W-1] ? n : v;
  endfunction

  // Apply the sign and clamp to the output range
  function automatic logic [OUT_W-1:0] clamp_q(input logic [QB-1:0] q, input logic neg);
    logic [QB-1:0] nq;
    nq = -q;
    if (neg) begin
      return (q > Q_NEG_LIM) ? OUT_MIN : nq[OUT_W-1:0];
    end
    return (q > Q_POS_LIM) ? OUT_MAX : q[OUT_W-1:0];
  endfunction

  logic                 busy_r, axis_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ACC_W-1:0]     rem_r, magy_r;
  logic                 negx_r, negy_r, zero_r, sat_r;
  logic [DW-1:0]        d3, d3_r;
  logic [DSW-1:0]       ds_r;
  logic [QB-1:0]        q_r, q_fin;
  logic                 ge;
  logic [OUT_W-1:0]     res, resx_r;
  logic [OUT_W-1:0]     cx_r, cy_r;
  logic                 za_r, st_r;

  assign d3    = {1'b0, tw, 1'b0} + {2'b00, tw};
  assign ge    = {{(DSW-ACC_W){1'b0}}, rem_r} >= ds_r;
  assign q_fin = {q_r[QB-2:0], ge};
  assign res   = clamp_q(q_fin, axis_r ? negy_r : negx_r);

  // Busy and axis control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      axis_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      axis_r <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= ~axis_r;
      axis_r <= ~axis_r;
    end
  end

  // One restoring step a cycle, x axis then y axis
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r  <= magnitude(sum_x);
      magy_r <= magnitude(sum_y);
      negx_r <= sum_x[ACC_W-1];
      negy_r <= sum_y[ACC_W-1];
      d3_r   <= d3;
      ds_r   <= {d3, {(QB-1){1'b0}}};
      q_r    <= '0;
      cnt_r  <= CNT_W'(QB - 1);
      zero_r <= (tw == '0);
      sat_r  <= ovf;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        if (!axis_r) begin
          resx_r <= res;
          rem_r  <= magy_r;
          ds_r   <= {d3_r, {(QB-1){1'b0}}};
          q_r    <= '0;
          cnt_r  <= CNT_W'(QB - 1);
        end else begin
          q_r <= q_fin;
        end
      end else begin
        if (ge) begin
          rem_r <= rem_r - ds_r[ACC_W-1:0];
        end
        q_r   <= q_fin;
        ds_r  <= ds_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cx_r <= zero_r ? '0 : resx_r;
      cy_r <= zero_r ? '0 : clamp_q(q_r, negy_r);
      za_r <= zero_r;
      st_r <= sat_r;
    end
  end

  assign busy       = busy_r;
  assign centroid_x = cx_r;
  assign centroid_y = cy_r;
  assign zero_area  = za_r;
  assign saturated  = st_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("divide started while busy");
  a_done_after_y: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(axis_r))
    else $error("divide ended before second axis");
  a_x_to_y: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !axis_r && !cmd.start) |=> (busy_r && axis_r))
    else $error("second axis not started");
`endif

endmodule

[test/tb_area_weighted_triangle_centroid.sv]
module tb_area_weighted_triangle_centroid;
  timeunit 1ns;
  timeprecision 1ps;

  import awtc_pkg::*;

  localparam int RESULT_LATENCY = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1450;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] AREA_LIMIT = (64'd1 << TW_W) - 64'd1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
    logic   last;
  } triangle_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    zero_area;
    logic                    saturated;
  } centroid_t;

  typedef struct packed {
    triangle_t vertices;
    logic      typed;
    centroid_t want;
  } row_t;

  localparam coord_t C_MIN = 16'sh8000;
  localparam coord_t C_MAX = 16'sh7FFF;

  localparam centroid_t NO_CHECK    = '0;
  localparam centroid_t ZERO_RESULT = '{16'sd0, 16'sd0, 1'b1, 1'b0};
  localparam centroid_t SMALL_RESULT = '{16'sd16, 16'sd16, 1'b0, 1'b0};

  // Directed stimulus: extremes, degenerate shapes, sign and truncation cases
  localparam int NUM_DIRECTED = 23;
  localparam row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1, ZERO_RESULT},
    '{'{C_MIN, C_MIN, 16'sd0, 16'sd0, C_MAX, C_MAX, 1'b1}, 1'b1, ZERO_RESULT},
    '{'{16'sd0, 16'sd0, 16'sd48, 16'sd0, 16'sd0, 16'sd48, 1'b1}, 1'b1, SMALL_RESULT},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd48, 16'sd48, 16'sd0, 1'b1}, 1'b1, SMALL_RESULT},
    '{'{C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 1'b1}, 1'b0, NO_CHECK},
    '{'{C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 1'b1}, 1'b0, NO_CHECK},
    '{'{C_MIN, C_MIN, C_MIN, C_MAX, 16'sd16384, C_MIN, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd160, 1'b0}, 1'b0, NO_CHECK},
    '{'{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b0}, 1'b0, NO_CHECK},
    '{'{16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'sd0, 16'sd160, 1'b1}, 1'b0, NO_CHECK},
    '{'{-16'sd1, -16'sd1, -16'sd2, -16'sd1, -16'sd1, -16'sd2, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh0F0F, 16'shF0F0, 1'b1},
      1'b0, NO_CHECK},
    '{'{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 16'shF0F0, 16'sh0F0F, 1'b0},
      1'b0, NO_CHECK},
    '{'{C_MAX, 16'sd0, 16'sd0, C_MAX, C_MIN, C_MIN, 1'b1}, 1'b0, NO_CHECK},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1}, 1'b1, ZERO_RESULT},
    '{'{-16'sd100, -16'sd100, 16'sd300, -16'sd50, 16'sd250, 16'sd400, 1'b0},
      1'b0, NO_CHECK},
    '{'{-16'sd100, -16'sd100, 16'sd250, 16'sd400, -16'sd200, 16'sd350, 1'b0},
      1'b0, NO_CHECK},
    '{'{-16'sd100, -16'sd100, -16'sd200, 16'sd350, -16'sd350, 16'sd0, 1'b1},
      1'b0, NO_CHECK},
    '{'{16'sd7, 16'sd9, 16'sd7, 16'sd9, 16'sd100, 16'sd200, 1'b0}, 1'b0, NO_CHECK},
    '{'{-16'sd3, -16'sd3, -16'sd3, -16'sd3, -16'sd3, -16'sd3, 1'b1}, 1'b1, ZERO_RESULT},
    '{'{C_MAX, C_MIN, C_MIN, C_MAX, 16'sd0, 16'sd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'sd0, C_MIN, C_MAX, 16'sd0, C_MIN, C_MAX, 1'b1}, 1'b0, NO_CHECK}
  };

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  coord_t                  in_ax            = '0;
  coord_t                  in_ay            = '0;
  coord_t                  in_bx            = '0;
  coord_t                  in_by_coord      = '0;
  coord_t                  in_cx            = '0;
  coord_t                  in_cy            = '0;
  logic                    in_last_triangle = 1'b0;
  logic                    out_valid;
  logic                    out_stall        = 1'b0;
  logic signed [OUT_W-1:0] out_centroid_x;
  logic signed [OUT_W-1:0] out_centroid_y;
  logic                    out_zero_area;
  logic                    out_saturated;

  area_weighted_triangle_centroid u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ax            (in_ax),
    .in_ay            (in_ay),
    .in_bx            (in_bx),
    .in_by_coord      (in_by_coord),
    .in_cx            (in_cx),
    .in_cy            (in_cy),
    .in_last_triangle (in_last_triangle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y),
    .out_zero_area    (out_zero_area),
    .out_saturated    (out_saturated)
  );

  // Predicted shape sums and the centroids still owed by the block
  logic signed [ACC_W-1:0] moment_x;
  logic signed [ACC_W-1:0] moment_y;
  logic [63:0]             area_total;
  bit                      clamp_seen;
  centroid_t               pending_centroids [$];

  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed add that clamps at the 64-bit limits
  function automatic logic signed [ACC_W-1:0] add_clamped(logic signed [ACC_W-1:0] a,
                                                          logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] r;
    r = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && r[ACC_W-1] != a[ACC_W-1]) begin
      clamp_seen = 1'b1;
      r = b[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return r;
  endfunction

  // Vertex sum times weight, clamped when the magnitude exceeds the signed maximum
  function automatic logic signed [ACC_W-1:0] mul_clamped(logic signed [ACC_W-1:0] s,
                                                          logic [63:0] w);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag  = s[ACC_W-1] ? (64'd0 - s) : s;
    prod = {64'd0, mag} * {64'd0, w};
    if (prod > {64'd0, ACC_MAX}) begin
      clamp_seen = 1'b1;
      return s[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1] ? (64'd0 - prod[63:0]) : prod[63:0];
  endfunction

  // Moment over three times the area, truncated toward zero and clamped to 16 bits
  function automatic logic signed [OUT_W-1:0] centroid_axis(logic signed [ACC_W-1:0] sum,
                                                            logic [63:0] area);
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] neg_quot;
    mag  = sum[ACC_W-1] ? (64'd0 - sum) : sum;
    quot = mag / (64'd3 * area);
    neg_quot = 64'd0 - quot;
    if (sum[ACC_W-1])
      return (quot > 64'd32768) ? C_MIN : neg_quot[OUT_W-1:0];
    return (quot > 64'd32767) ? C_MAX : quot[OUT_W-1:0];
  endfunction

  // Fold one triangle into the shape sums; close the shape on the last one
  task automatic fold_triangle(input triangle_t t, output bit done, output centroid_t c);
    longint      ax, ay, bx, by, cx, cy;
    longint      cross_prod;
    logic [63:0] w;
    ax = t.ax;
    ay = t.ay;
    bx = t.bx;
    by = t.by_coord;
    cx = t.cx;
    cy = t.cy;
    cross_prod = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
    w = (cross_prod < 0) ? -cross_prod : cross_prod;
    moment_x = add_clamped(moment_x, mul_clamped(ax + bx + cx, w));
    moment_y = add_clamped(moment_y, mul_clamped(ay + by + cy, w));
    if (w > AREA_LIMIT - area_total) begin
      area_total = AREA_LIMIT;
      clamp_seen = 1'b1;
    end else begin
      area_total = area_total + w;
    end
    done = t.last;
    c = '0;
    if (t.last) begin
      if (area_total == 64'd0) begin
        c.zero_area = 1'b1;
      end else begin
        c.x = centroid_axis(moment_x, area_total);
        c.y = centroid_axis(moment_y, area_total);
      end
      c.saturated = clamp_seen;
      moment_x   = '0;
      moment_y   = '0;
      area_total = '0;
      clamp_seen = 1'b0;
    end
  endtask

  function automatic coord_t jitter(coord_t base, int unsigned reach);
    logic [31:0] step;
    step = $urandom_range(0, 2 * reach) - reach;
    return base + step[COORD_W-1:0];
  endfunction

  // Uniform coordinate over the full 16-bit range
  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[COORD_W-1:0];
  endfunction

  // Random triangle: full range, local clusters, corner values or degenerate
  function automatic triangle_t random_triangle();
    triangle_t   t;
    coord_t      base_x;
    coord_t      base_y;
    coord_t      corner [4];
    int unsigned reach;
    corner = '{C_MIN, C_MAX, 16'sd0, -16'sd1};
    base_x = rand_coord();
    base_y = rand_coord();
    t = '0;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        t.ax = rand_coord();
        t.ay = rand_coord();
        t.bx = rand_coord();
        t.by_coord = rand_coord();
        t.cx = rand_coord();
        t.cy = rand_coord();
      end
      4, 5, 6, 7: begin
        case ($urandom_range(3))
          0: reach = 3;
          1: reach = 40;
          2: reach = 255;
          default: reach = 4000;
        endcase
        t.ax = jitter(base_x, reach);
        t.ay = jitter(base_y, reach);
        t.bx = jitter(base_x, reach);
        t.by_coord = jitter(base_y, reach);
        t.cx = jitter(base_x, reach);
        t.cy = jitter(base_y, reach);
      end
      8: begin
        t.ax = corner[$urandom_range(3)];
        t.ay = corner[$urandom_range(3)];
        t.bx = corner[$urandom_range(3)];
        t.by_coord = corner[$urandom_range(3)];
        t.cx = corner[$urandom_range(3)];
        t.cy = corner[$urandom_range(3)];
      end
      default: begin
        t.ax = base_x;
        t.ay = base_y;
        t.bx = rand_coord();
        t.by_coord = rand_coord();
        if ($urandom_range(1)) begin
          t.cx = base_x;
          t.cy = base_y;
        end else begin
          t.cx = t.bx;
          t.cy = t.by_coord;
        end
      end
    endcase
    return t;
  endfunction

  // Offer one triangle request, hold it until taken, then predict
  task automatic push_triangle(input triangle_t t, input logic typed, input centroid_t want);
    bit        done;
    centroid_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_ax            <= t.ax;
    in_ay            <= t.ay;
    in_bx            <= t.bx;
    in_by_coord      <= t.by_coord;
    in_cx            <= t.cx;
    in_cy            <= t.cy;
    in_last_triangle <= t.last;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_triangle(t, done, c);
    if (done)
      pending_centroids.push_back(typed ? want : c);
    @(negedge clk);
  endtask

  // Hold off new requests until every owed centroid has arrived
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_centroids.size() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted centroid with the oldest prediction
  always @(posedge clk) begin : result_check
    centroid_t got;
    centroid_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.x         = out_centroid_x;
      got.y         = out_centroid_y;
      got.zero_area = out_zero_area;
      got.saturated = out_saturated;
      if (pending_centroids.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected centroid: x=%0d y=%0d zero=%0b sat=%0b",
                   got.x, got.y, got.zero_area, got.saturated);
      end else begin
        want = pending_centroids.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("centroid mismatch: want x=%0d y=%0d zero=%0b sat=%0b,",
                     want.x, want.y, want.zero_area, want.saturated,
                     " got x=%0d y=%0d zero=%0b sat=%0b",
                     got.x, got.y, got.zero_area, got.saturated);
        end
      end
    end
  end

  // Abort when neither channel moves a request for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent;
    sent       = 0;
    moment_x   = '0;
    moment_y   = '0;
    area_total = '0;
    clamp_seen = 1'b0;

    // Hold reset, then release it
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_for_drain();

      // Walk the directed table once
      if (phase == 0) begin
        for (int i = 0; i < NUM_DIRECTED; i++)
          push_triangle(DIRECTED_ROWS[i].vertices, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].want);
      end

      // Random shapes, mostly short, now and then all degenerate
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin : one_shape
        int        len;
        bit        flat;
        triangle_t t;
        len  = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        flat = ($urandom_range(29) == 0);
        for (int k = 0; k < len; k++) begin
          t = random_triangle();
          if (flat) begin
            t.cx = t.ax;
            t.cy = t.ay;
          end
          t.last = (k == len - 1);
          push_triangle(t, 1'b0, NO_CHECK);
          sent++;
        end
        if ($urandom_range(19) == 0)
          wait_for_drain();
      end
    end

    // Drain, then allow for anything late
    wait_for_drain();
    repeat (RESULT_LATENCY + 16) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
